// File: src/clsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clsc_pkg;

  localparam int MaxData    = 1024;
  localparam int MaxCredits = 8;
  localparam int FlushLimit = 4;
  localparam int RevReset   = 1;
  localparam int QDepth     = 2;

  localparam int CmdW    = 2;
  localparam int RevW    = 8;
  localparam int KindW   = 3;
  localparam int LenW    = 16;
  localparam int GrantW  = 16;
  localparam int IpW     = 32;
  localparam int PortW   = 16;
  localparam int AppendW = 11;
  localparam int ActW    = 3;
  localparam int ErrW    = 2;

  localparam int PendW    = $clog2(MaxData + 1);
  localparam int CreditW  = $clog2(MaxCredits + 1);
  localparam int CSumW    = GrantW + 1;
  localparam int CmpW     = (PendW > AppendW) ? PendW : AppendW;
  localparam int FlCntW   = $clog2(FlushLimit + 1);
  localparam int LowRoom  = MaxData / 4;
  localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_PACKET = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    K_DATA    = 3'd0,
    K_OPEN    = 3'd1,
    K_RESET   = 3'd2,
    K_CLOSE   = 3'd3,
    K_ERROR   = 3'd4,
    K_STOP    = 3'd5,
    K_START   = 3'd6,
    K_UNKNOWN = 3'd7
  } kind_e;

  typedef enum logic [ActW-1:0] {
    A_DONE    = 3'd0,
    A_DELIVER = 3'd1,
    A_ERROR   = 3'd2,
    A_SEND    = 3'd3,
    A_BLOCKED = 3'd4,
    A_DISCARD = 3'd5
  } act_e;

  typedef enum logic [ErrW-1:0] {
    ERR_BAD_REV    = 2'd0,
    ERR_CONN_RESET = 2'd1,
    ERR_IN_USE     = 2'd2
  } err_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic                 rev_ok;
    logic                 drop;
    kind_e                kind;
    logic [LenW-1:0]      dlen;
    logic [GrantW-1:0]    grant;
    logic [IpW-1:0]       ip;
    logic [PortW-1:0]     port;
    logic [AppendW-1:0]   count;
  } item_t;

  typedef struct packed {
    act_e              action;
    logic [LenW-1:0]   length;
    err_e              error_code;
    logic              session_open;
    logic              stopped;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// File: src/clsc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clsc_req_if;
  logic                               valid;
  logic                               ready;
  logic [clsc_pkg::CmdW-1:0]          command;
  logic [clsc_pkg::RevW-1:0]          pkt_revision;
  logic [clsc_pkg::KindW-1:0]         pkt_kind;
  logic                               header_short;
  logic [clsc_pkg::LenW-1:0]          payload_bytes;
  logic [clsc_pkg::LenW-1:0]          declared_length;
  logic [clsc_pkg::GrantW-1:0]        credit_grant;
  logic [clsc_pkg::IpW-1:0]           source_ip;
  logic [clsc_pkg::PortW-1:0]         source_port;
  logic [clsc_pkg::AppendW-1:0]       append_count;

  modport source (
    output valid, command, pkt_revision, pkt_kind, header_short, payload_bytes,
           declared_length, credit_grant, source_ip, source_port, append_count,
    input  ready
  );
  modport sink (
    input  valid, command, pkt_revision, pkt_kind, header_short, payload_bytes,
           declared_length, credit_grant, source_ip, source_port, append_count,
    output ready
  );
endinterface

interface clsc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [clsc_pkg::ActW-1:0]    action;
  logic [clsc_pkg::LenW-1:0]    length;
  logic [clsc_pkg::ErrW-1:0]    error_code;
  logic                         session_open;
  logic                         stopped;
  logic                         last;

  modport source (
    output valid, action, length, error_code, session_open, stopped, last,
    input  ready
  );
  modport sink (
    input  valid, action, length, error_code, session_open, stopped, last,
    output ready
  );
endinterface

interface clsc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [clsc_pkg::RevW-1:0]    protocol_revision;

  modport source (output valid, protocol_revision, input ready);
  modport sink (input valid, protocol_revision, output ready);
endinterface

`default_nettype wire

// File: src/clsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module clsc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  clsc_req_if.sink          req_i,
  clsc_cfg_if.sink          cfg_i,
  output clsc_pkg::item_t   q_item_o,
  output logic              q_valid_o,
  input  logic              q_pop_i
);

  logic [clsc_pkg::RevW-1:0]  rev_q;
  clsc_pkg::item_t            item_in;
  clsc_pkg::item_t            slot_q [clsc_pkg::QDepth];
  logic [clsc_pkg::QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [clsc_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                       push, pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q <= clsc_pkg::RevW'(clsc_pkg::RevReset);
    end else if (cfg_i.valid) begin
      rev_q <= cfg_i.protocol_revision;
    end
  end

  // classify the packet checks that need no session state
  always_comb begin
    item_in.cmd    = clsc_pkg::cmd_e'(req_i.command);
    item_in.rev_ok = (req_i.pkt_revision == rev_q);
    item_in.drop   = req_i.header_short | (req_i.payload_bytes < req_i.declared_length);
    item_in.kind   = clsc_pkg::kind_e'(req_i.pkt_kind);
    item_in.dlen   = req_i.declared_length;
    item_in.grant  = req_i.credit_grant;
    item_in.ip     = req_i.source_ip;
    item_in.port   = req_i.source_port;
    item_in.count  = req_i.append_count;
  end

  assign req_i.ready = (cnt_q != clsc_pkg::QCntW'(clsc_pkg::QDepth));
  assign q_valid_o   = (cnt_q != '0);
  assign q_item_o    = slot_q[rd_q];
  assign push        = req_i.valid & req_i.ready;
  assign pop         = q_pop_i & q_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == clsc_pkg::QPtrW'(clsc_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == clsc_pkg::QPtrW'(clsc_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

// File: src/clsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module clsc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clsc_pkg::item_t   q_item_i,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  clsc_rsp_if.source        rsp_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ERR   = 6'b000010,
    S_FLUSH = 6'b000100,
    S_PKT   = 6'b001000,
    S_APP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    FC_END    = 2'd0,
    FC_PKT    = 2'd1,
    FC_APPEND = 2'd2
  } ctx_e;

  state_e                         state_q, state_d;
  ctx_e                           ctx_q, ctx_d;
  clsc_pkg::err_e                 err_q, err_d;
  logic                           emitted_q, emitted_d;
  clsc_pkg::item_t                item_q, item_d;
  logic [clsc_pkg::AppendW-1:0]   rem_q, rem_d, acc_q, acc_d;
  logic [clsc_pkg::FlCntW-1:0]    nfl_q, nfl_d;
  logic                           conv_q, conv_d, stop_q, stop_d;
  logic [clsc_pkg::CreditW-1:0]   credit_q, credit_d, credit_add;
  logic [clsc_pkg::PendW-1:0]     pend_q, pend_d, pend_fill;
  logic [clsc_pkg::IpW-1:0]       peer_ip_q, peer_ip_d;
  logic [clsc_pkg::PortW-1:0]     peer_port_q, peer_port_d;
  logic [clsc_pkg::CSumW-1:0]     credit_sum;
  logic [clsc_pkg::CmpW-1:0]      room, take;
  logic                           conflict, pend_zero, low_room, blocked;
  logic                           want, adv, slot_free, emit_fire;
  clsc_pkg::result_t              rslt, out_q;
  logic                           out_valid_q;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign adv       = !want || slot_free;
  assign emit_fire = want && slot_free;

  always_comb begin
    state_d     = state_q;
    ctx_d       = ctx_q;
    err_d       = err_q;
    emitted_d   = emitted_q;
    item_d      = item_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    nfl_d       = nfl_q;
    conv_d      = conv_q;
    stop_d      = stop_q;
    credit_d    = credit_q;
    pend_d      = pend_q;
    peer_ip_d   = peer_ip_q;
    peer_port_d = peer_port_q;
    q_pop_o     = 1'b0;
    want        = 1'b0;
    blocked     = 1'b0;

    rslt.action     = clsc_pkg::A_DONE;
    rslt.length     = '0;
    rslt.error_code = clsc_pkg::ERR_BAD_REV;
    rslt.last       = 1'b0;

    conflict   = conv_q && ((item_q.ip != peer_ip_q) || (item_q.port != peer_port_q));
    pend_zero  = (pend_q == '0);
    credit_sum = clsc_pkg::CSumW'(credit_q) + clsc_pkg::CSumW'(item_q.grant);
    credit_add = (credit_sum > clsc_pkg::CSumW'(clsc_pkg::MaxCredits))
               ? clsc_pkg::CreditW'(clsc_pkg::MaxCredits) : credit_sum[clsc_pkg::CreditW-1:0];
    room       = clsc_pkg::CmpW'(clsc_pkg::MaxData) - clsc_pkg::CmpW'(pend_q);
    take       = (clsc_pkg::CmpW'(rem_q) < room) ? clsc_pkg::CmpW'(rem_q) : room;
    pend_fill  = pend_q + take[clsc_pkg::PendW-1:0];
    low_room   = (clsc_pkg::CmpW'(clsc_pkg::MaxData) - clsc_pkg::CmpW'(pend_fill))
               < clsc_pkg::CmpW'(clsc_pkg::LowRoom);

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          item_d    = q_item_i;
          emitted_d = 1'b0;
          acc_d     = '0;
          rem_d     = q_item_i.count;
          nfl_d     = '0;
          ctx_d     = FC_END;
          case (q_item_i.cmd)
            clsc_pkg::CMD_PACKET: begin
              if (!q_item_i.rev_ok) begin
                err_d   = clsc_pkg::ERR_BAD_REV;
                state_d = S_ERR;
              end else if (q_item_i.drop) begin
                state_d = S_DONE;
              end else if (q_item_i.kind == clsc_pkg::K_RESET) begin
                err_d   = clsc_pkg::ERR_CONN_RESET;
                ctx_d   = FC_PKT;
                state_d = S_ERR;
              end else begin
                state_d = S_PKT;
              end
            end
            clsc_pkg::CMD_APPEND: state_d = S_APP;
            clsc_pkg::CMD_FLUSH:  state_d = S_FLUSH;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_ERR: begin
        want            = 1'b1;
        emitted_d       = 1'b1;
        rslt.action     = clsc_pkg::A_ERROR;
        rslt.error_code = err_q;
        rslt.last       = pend_zero && ((ctx_q == FC_END) || !conflict);
        state_d         = S_FLUSH;
      end
      S_FLUSH: begin
        if (!pend_zero) begin
          want        = 1'b1;
          emitted_d   = 1'b1;
          rslt.length = clsc_pkg::LenW'(pend_q);
          if (!conv_q) begin
            rslt.action = clsc_pkg::A_DISCARD;
            pend_d      = '0;
          end else if (stop_q || (credit_q == '0)) begin
            rslt.action = clsc_pkg::A_BLOCKED;
            blocked     = 1'b1;
          end else begin
            rslt.action = clsc_pkg::A_SEND;
            credit_d    = credit_q - 1'b1;
            pend_d      = '0;
          end
        end
        case (ctx_q)
          FC_PKT: begin
            rslt.last = !conflict;
            state_d   = S_PKT;
          end
          FC_APPEND: begin
            rslt.last = 1'b0;
            state_d   = blocked ? S_DONE : S_APP;
          end
          default: begin
            rslt.last = 1'b1;
            state_d   = (!pend_zero || emitted_q) ? S_IDLE : S_DONE;
          end
        endcase
      end
      S_PKT: begin
        if (conflict) begin
          err_d   = clsc_pkg::ERR_IN_USE;
          ctx_d   = FC_END;
          state_d = S_ERR;
        end else begin
          state_d = emitted_q ? S_IDLE : S_DONE;
          case (item_q.kind)
            clsc_pkg::K_DATA: begin
              credit_d = credit_add;
              if (!conv_q) begin
                conv_d      = 1'b1;
                peer_ip_d   = item_q.ip;
                peer_port_d = item_q.port;
              end
              want        = 1'b1;
              emitted_d   = 1'b1;
              rslt.action = clsc_pkg::A_DELIVER;
              rslt.length = item_q.dlen;
              rslt.last   = 1'b1;
              state_d     = S_IDLE;
            end
            clsc_pkg::K_OPEN, clsc_pkg::K_RESET: begin
              conv_d      = 1'b1;
              credit_d    = credit_add;
              peer_ip_d   = item_q.ip;
              peer_port_d = item_q.port;
            end
            clsc_pkg::K_CLOSE: conv_d = 1'b0;
            clsc_pkg::K_STOP:  stop_d = 1'b1;
            clsc_pkg::K_START: stop_d = 1'b0;
            default: ;
          endcase
        end
      end
      S_APP: begin
        if ((rem_q == '0) || (nfl_q == clsc_pkg::FlCntW'(clsc_pkg::FlushLimit))) begin
          state_d = S_DONE;
        end else begin
          pend_d = pend_fill;
          rem_d  = rem_q - take[clsc_pkg::AppendW-1:0];
          acc_d  = acc_q + take[clsc_pkg::AppendW-1:0];
          if (low_room) begin
            nfl_d   = nfl_q + 1'b1;
            ctx_d   = FC_APPEND;
            state_d = S_FLUSH;
          end
        end
      end
      S_DONE: begin
        want        = 1'b1;
        rslt.action = clsc_pkg::A_DONE;
        rslt.length = clsc_pkg::LenW'(acc_q);
        rslt.last   = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    rslt.session_open = conv_d;
    rslt.stopped      = stop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ctx_q       <= FC_END;
      err_q       <= clsc_pkg::ERR_BAD_REV;
      emitted_q   <= 1'b0;
      rem_q       <= '0;
      acc_q       <= '0;
      nfl_q       <= '0;
      conv_q      <= 1'b0;
      stop_q      <= 1'b0;
      credit_q    <= '0;
      pend_q      <= '0;
      peer_ip_q   <= '0;
      peer_port_q <= '0;
    end else if (adv) begin
      state_q     <= state_d;
      ctx_q       <= ctx_d;
      err_q       <= err_d;
      emitted_q   <= emitted_d;
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      nfl_q       <= nfl_d;
      conv_q      <= conv_d;
      stop_q      <= stop_d;
      credit_q    <= credit_d;
      pend_q      <= pend_d;
      peer_ip_q   <= peer_ip_d;
      peer_port_q <= peer_port_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item_q <= item_d;
    end
  end

  // output register, decouples the sequencer from the receiver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q <= rslt;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.action       = out_q.action;
  assign rsp_o.length       = out_q.length;
  assign rsp_o.error_code   = out_q.error_code;
  assign rsp_o.session_open = out_q.session_open;
  assign rsp_o.stopped      = out_q.stopped;
  assign rsp_o.last         = out_q.last;

endmodule

`default_nettype wire

// File: src/console_link_session_control.sv
// Session control for one network console channel.
// req_i takes one beat per event: a received packet header, an append of
// output bytes or a flush request. rsp_o gives one to five result beats per
// event, in order; the final beat of each event has last set.
// cfg_i writes the protocol revision that received headers must carry; it
// is always ready. The user must write it only while no event is in
// flight; the block itself does not enforce this.
// A front stage checks revision and length and places the event in a
// two-entry queue; a back sequencer owns the session state and writes its
// results, one at a time, into an output register.
// The sequencer takes the next event from the queue only once it is back
// in idle, and each event walks through the packet, append, error, flush
// and done steps that it needs. Each beat is registered in the queue and
// the sequencer, and each result in the output register.
// req_i keeps accepting while the queue has room, also while a result
// waits on rsp_o. A stalled receiver holds the result beat and the
// sequencer, and the queue then fills and drops req_i.ready.
// Reset clears the session, stop flag, credits, pending bytes and peer, and
// sets the revision to 1.
`timescale 1ns / 1ps
`default_nettype none

module console_link_session_control (
  input  logic        clk_i,
  input  logic        rst_ni,
  clsc_req_if.sink    req_i,
  clsc_cfg_if.sink    cfg_i,
  clsc_rsp_if.source  rsp_o
);

  clsc_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  clsc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cfg_i     (cfg_i),
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  clsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_item_i  (q_item),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

  a_deliver_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.action == clsc_pkg::A_DELIVER)) |-> rsp_o.session_open)
    else $error("deliver reported without an open session");

  a_send_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.action == clsc_pkg::A_SEND)) |-> (rsp_o.session_open && !rsp_o.stopped))
    else $error("data sent while closed or stopped");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.action == clsc_pkg::A_DONE)) |-> rsp_o.last)
    else $error("done beat not marked last");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.action != clsc_pkg::A_ERROR)) |-> (rsp_o.error_code == clsc_pkg::ERR_BAD_REV))
    else $error("error code set on a non-error beat");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import clsc_pkg::*;

  localparam int unsigned Limit = 400000;
  // error field reads zero outside an error beat
  localparam err_e ErrNone = ERR_BAD_REV;

  typedef struct {
    cmd_e               command;
    logic [RevW-1:0]    rev;
    kind_e              kind;
    logic               hshort;
    logic [LenW-1:0]    payload;
    logic [LenW-1:0]    dlen;
    logic [GrantW-1:0]  grant;
    logic [IpW-1:0]     ip;
    logic [PortW-1:0]   port;
    logic [AppendW-1:0] count;
  } event_t;

  class session_scoreboard;
    logic [RevW-1:0]  revision;
    bit               conversing;
    bit               stop_flag;
    int unsigned      credits;
    int unsigned      pending;
    logic [IpW-1:0]   peer_ip;
    logic [PortW-1:0] peer_port;
    result_t          expected_q[$];
    result_t          beats[$];
    int               errors;

    function new();
      revision   = RevW'(RevReset);
      conversing = 0;
      stop_flag  = 0;
      credits    = 0;
      pending    = 0;
      peer_ip    = '0;
      peer_port  = '0;
      errors     = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void emit(act_e a, int unsigned len, err_e e);
      result_t r;
      r.action       = a;
      r.length       = LenW'(len);
      r.error_code   = e;
      r.session_open = conversing;
      r.stopped      = stop_flag;
      r.last         = 1'b0;
      beats.push_back(r);
    endfunction

    function void add_credit(logic [GrantW-1:0] grant);
      credits = credits + grant;
      if (credits > MaxCredits) credits = MaxCredits;
    endfunction

    function void flush_rule();
      if (pending == 0) return;
      if (!conversing) begin
        emit(A_DISCARD, pending, ErrNone);
        pending = 0;
      end else if (stop_flag || credits == 0) begin
        emit(A_BLOCKED, pending, ErrNone);
      end else begin
        emit(A_SEND, pending, ErrNone);
        credits--;
        pending = 0;
      end
    endfunction

    function void error_reply(err_e code);
      emit(A_ERROR, 0, code);
      flush_rule();
    endfunction

    function void take_packet(event_t ev);
      if (ev.rev != revision) begin
        error_reply(ERR_BAD_REV);
        return;
      end
      if (ev.hshort || ev.payload < ev.dlen) return;
      if (ev.kind == K_RESET) error_reply(ERR_CONN_RESET);
      if (conversing && (ev.ip != peer_ip || ev.port != peer_port)) begin
        error_reply(ERR_IN_USE);
        return;
      end
      case (ev.kind)
        K_DATA: begin
          add_credit(ev.grant);
          if (!conversing) begin
            conversing = 1;
            peer_ip    = ev.ip;
            peer_port  = ev.port;
          end
          emit(A_DELIVER, ev.dlen, ErrNone);
        end
        K_OPEN, K_RESET: begin
          conversing = 1;
          add_credit(ev.grant);
          peer_ip   = ev.ip;
          peer_port = ev.port;
        end
        K_CLOSE: conversing = 0;
        K_STOP:  stop_flag = 1;
        K_START: stop_flag = 0;
        default: ;
      endcase
    endfunction

    function void take_append(logic [AppendW-1:0] count);
      int unsigned left;
      int unsigned room;
      int unsigned take;
      int unsigned accepted;
      int          flushes;
      left     = count;
      accepted = 0;
      flushes  = 0;
      while (left > 0 && flushes < FlushLimit) begin
        room     = MaxData - pending;
        take     = (left < room) ? left : room;
        pending += take;
        accepted += take;
        left    -= take;
        if (MaxData - pending < LowRoom) begin
          flush_rule();
          flushes++;
          if (pending != 0) break;
        end
      end
      emit(A_DONE, accepted, ErrNone);
    endfunction

    function void note_event(event_t ev);
      result_t r;
      beats.delete();
      case (ev.command)
        CMD_PACKET: take_packet(ev);
        CMD_APPEND: take_append(ev.count);
        CMD_FLUSH:  flush_rule();
        default:    ;
      endcase
      if (beats.size() == 0) emit(A_DONE, 0, ErrNone);
      r = beats.pop_back();
      r.last = 1'b1;
      beats.push_back(r);
      foreach (beats[i]) expected_q.push_back(beats[i]);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: action %0d length %0d",
               got.action, got.length);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("action", want.action, got.action);
      cmp_field("length", want.length, got.length);
      cmp_field("error_code", want.error_code, got.error_code);
      cmp_field("session_open", want.session_open, got.session_open);
      cmp_field("stopped", want.stopped, got.stopped);
      cmp_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  clsc_req_if req_if ();
  clsc_cfg_if cfg_if ();
  clsc_rsp_if rsp_if ();

  console_link_session_control i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .rsp_o  (rsp_if)
  );

  session_scoreboard sb = new();

  bit send_calm;
  bit rsp_calm;
  int unsigned cycle_count = 0;

  logic [IpW-1:0]   peer_ips[3];
  logic [PortW-1:0] peer_ports[3];

  kind_e kind_mix[16] = '{K_DATA, K_DATA, K_DATA, K_DATA, K_DATA, K_OPEN, K_OPEN,
                          K_OPEN, K_RESET, K_CLOSE, K_CLOSE, K_STOP, K_START,
                          K_START, K_ERROR, K_UNKNOWN};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == Limit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic event_t noise_event();
    event_t ev;
    ev.command = cmd_e'($urandom_range(0, 3));
    ev.rev     = RevW'($urandom);
    ev.kind    = kind_e'($urandom_range(0, 7));
    ev.hshort  = 1'($urandom);
    ev.payload = LenW'($urandom);
    ev.dlen    = LenW'($urandom);
    ev.grant   = GrantW'($urandom);
    ev.ip      = $urandom;
    ev.port    = PortW'($urandom);
    ev.count   = AppendW'($urandom_range(0, 1024));
    return ev;
  endfunction

  function automatic event_t packet_from(kind_e k, int p, logic [GrantW-1:0] grant,
                                         logic [LenW-1:0] dlen);
    event_t ev;
    ev         = noise_event();
    ev.command = CMD_PACKET;
    ev.rev     = sb.revision;
    ev.kind    = k;
    ev.hshort  = 1'b0;
    ev.dlen    = dlen;
    ev.payload = dlen;
    ev.grant   = grant;
    ev.ip      = peer_ips[p];
    ev.port    = peer_ports[p];
    return ev;
  endfunction

  function automatic event_t op_event(cmd_e c, logic [AppendW-1:0] n);
    event_t ev;
    ev         = noise_event();
    ev.command = c;
    ev.count   = n;
    return ev;
  endfunction

  function automatic event_t random_event();
    event_t      ev;
    int unsigned pick;
    int unsigned who;
    ev   = noise_event();
    pick = $urandom_range(0, 99);
    if (pick < 8) return ev;
    if (pick < 50) begin
      ev.command = CMD_PACKET;
      if ($urandom_range(0, 19) != 0) ev.rev = sb.revision;
      ev.kind   = kind_mix[$urandom_range(0, 15)];
      ev.hshort = ($urandom_range(0, 11) == 0);
      if ($urandom_range(0, 7) != 0) ev.dlen = LenW'($urandom_range(0, 1500));
      if ($urandom_range(0, 9) == 0)
        ev.payload = (ev.dlen > 0) ? LenW'($urandom_range(0, ev.dlen - 1)) : '0;
      else
        ev.payload = (ev.dlen > 16'hFFD7) ? 16'hFFFF : ev.dlen + LenW'($urandom_range(0, 40));
      if ($urandom_range(0, 5) != 0) ev.grant = GrantW'($urandom_range(0, 3));
      who = $urandom_range(0, 19);
      if (who < 12) begin
        ev.ip   = peer_ips[0];
        ev.port = peer_ports[0];
      end else if (who < 15) begin
        ev.ip   = peer_ips[1];
        ev.port = peer_ports[1];
      end else if (who < 17) begin
        ev.ip   = peer_ips[2];
        ev.port = peer_ports[2];
      end else if (who < 18) begin
        ev.ip = peer_ips[0];
      end
    end else if (pick < 75) begin
      ev.command = CMD_APPEND;
      ev.count   = ($urandom_range(0, 2) == 0) ? AppendW'($urandom_range(700, 1024))
                                               : AppendW'($urandom_range(0, 300));
    end else if (pick < 95) begin
      ev.command = CMD_FLUSH;
    end else begin
      ev.command = CMD_NONE;
    end
    return ev;
  endfunction

  task automatic send_event(event_t ev);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.command         <= ev.command;
    req_if.pkt_revision    <= ev.rev;
    req_if.pkt_kind        <= ev.kind;
    req_if.header_short    <= ev.hshort;
    req_if.payload_bytes   <= ev.payload;
    req_if.declared_length <= ev.dlen;
    req_if.credit_grant    <= ev.grant;
    req_if.source_ip       <= ev.ip;
    req_if.source_port     <= ev.port;
    req_if.append_count    <= ev.count;
    req_if.valid           <= 1'b1;
    do @(posedge clk); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
    sb.note_event(ev);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_revision(logic [RevW-1:0] value);
    cfg_if.protocol_revision <= value;
    cfg_if.valid             <= 1'b1;
    do @(posedge clk); while (!(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1));
    cfg_if.valid <= 1'b0;
    sb.revision = value;
  endtask

  // result beat sink
  initial begin
    int      stall;
    result_t got;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap(rsp_calm);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
      got = result_t'({rsp_if.action, rsp_if.length, rsp_if.error_code,
                       rsp_if.session_open, rsp_if.stopped, rsp_if.last});
      sb.check_beat(got);
    end
  end

  initial begin
    event_t          ev;
    logic [RevW-1:0] revs[4];
    rst_n                    = 1'b0;
    req_if.valid            <= 1'b0;
    req_if.command          <= CMD_NONE;
    req_if.pkt_revision     <= '0;
    req_if.pkt_kind         <= K_DATA;
    req_if.header_short     <= 1'b0;
    req_if.payload_bytes    <= '0;
    req_if.declared_length  <= '0;
    req_if.credit_grant     <= '0;
    req_if.source_ip        <= '0;
    req_if.source_port      <= '0;
    req_if.append_count     <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.protocol_revision <= '0;

    peer_ips[0]   = 32'hFFFF_FFFF;
    peer_ports[0] = 16'hFFFF;
    peer_ips[1]   = 32'h0;
    peer_ports[1] = 16'h0;
    peer_ips[2]   = $urandom;
    peer_ports[2] = PortW'($urandom);
    revs[0] = 8'h00;
    revs[1] = 8'hFF;
    revs[2] = RevW'($urandom_range(2, 254));
    revs[3] = 8'h01;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats, revision at its reset value
    send_event(op_event(CMD_FLUSH, 0));
    send_event(op_event(CMD_NONE, 0));
    send_event(op_event(CMD_APPEND, 100));
    send_event(op_event(CMD_FLUSH, 0));
    ev = packet_from(K_OPEN, 0, 1, 0);
    ev.rev = 8'h00;
    send_event(ev);
    ev = packet_from(K_DATA, 0, 1, 10);
    ev.hshort = 1'b1;
    send_event(ev);
    ev = packet_from(K_DATA, 0, 1, 10);
    ev.payload = 9;
    send_event(ev);
    send_event(packet_from(K_DATA, 0, 16'hFFFF, 16'hFFFF));
    send_event(packet_from(K_DATA, 1, 1, 0));
    ev = packet_from(K_DATA, 0, 0, 0);
    ev.port = 16'h7FFF;
    send_event(ev);
    send_event(op_event(CMD_APPEND, 1024));
    send_event(packet_from(K_STOP, 0, 0, 0));
    send_event(op_event(CMD_APPEND, 1024));
    send_event(op_event(CMD_APPEND, 500));
    send_event(op_event(CMD_FLUSH, 0));
    send_event(packet_from(K_START, 0, 0, 0));
    send_event(op_event(CMD_FLUSH, 0));
    send_event(packet_from(K_ERROR, 0, 0, 0));
    send_event(packet_from(K_UNKNOWN, 0, 0, 0));
    send_event(op_event(CMD_APPEND, 200));
    send_event(packet_from(K_RESET, 1, 2, 0));
    send_event(packet_from(K_CLOSE, 0, 0, 0));
    send_event(packet_from(K_RESET, 1, 3, 0));
    ev = packet_from(K_OPEN, 1, 0, 0);
    ev.rev = 8'hFF;
    send_event(ev);
    send_event(op_event(CMD_APPEND, 0));

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_revision(revs[ph]);
      send_calm = (ph == 1);
      rsp_calm  = (ph == 2);
      for (int i = 0; i < 88; i++) begin
        if (ph == 3 && i == 44) wait_idle();
        send_event(random_event());
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
src/clsc_pkg.sv
src/clsc_if.sv
src/clsc_front.sv
src/clsc_back.sv
src/console_link_session_control.sv
tb/sv/testbench.sv
